// ===== sv/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, constants, segment table and control program of the
// seven-segment glyph line generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

    // field widths
    localparam int DIGIT_W = 5;
    localparam int POS_W   = 10;
    localparam int COLOR_W = 16;
    localparam int SIZE_W  = 10;
    localparam int DEPTH_W = 4;
    localparam int OUT_W   = 12;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 2;

    // bar depth saturates here
    localparam int MAX_DEPTH = 9;
    // max(depth/9, 2): depth never reaches 18, so the gap is always two
    localparam int GAP = 2;
    // half depth, and the per-loop line counter
    localparam int HALF_W = $clog2(MAX_DEPTH / 2 + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_DEPTH    = 2'd2;

    localparam logic [SIZE_W-1:0]  RESET_WIDTH  = 10'd32;
    localparam logic [SIZE_W-1:0]  RESET_HEIGHT = 10'd64;
    localparam logic [DEPTH_W-1:0] RESET_DEPTH  = 4'd8;

    // micro-operations
    localparam logic [1:0] OP_CALC  = 2'd0;  // latch the glyph base terms
    localparam logic [1:0] OP_LOAD  = 2'd1;  // load a segment's first line
    localparam logic [1:0] OP_EMIT1 = 2'd2;  // emit, outer bevel loop
    localparam logic [1:0] OP_EMIT2 = 2'd3;  // emit, inner bevel loop

    // start x select
    localparam logic [1:0] XS_A = 2'd0;      // x + d + s
    localparam logic [1:0] XS_R = 2'd1;      // x + w - d
    localparam logic [1:0] XS_L = 2'd2;      // x

    // start y select
    localparam logic [2:0] YS_TOP = 3'd0;    // y
    localparam logic [2:0] YS_T1  = 3'd1;    // y + d + s
    localparam logic [2:0] YS_B1  = 3'd2;    // y + h/2 + dh + s
    localparam logic [2:0] YS_BOT = 3'd3;    // y + h - d
    localparam logic [2:0] YS_MID = 3'd4;    // y + h/2 - dh

    // end y select of vertical bars
    localparam logic YE_T2 = 1'b0;           // y + h/2 - dh - s
    localparam logic YE_B2 = 1'b1;           // y + h - d - s

    typedef struct packed {
        logic [1:0] op;
        logic       horiz;
        logic [1:0] xs_sel;
        logic [2:0] ys_sel;
        logic       ye_sel;
        logic [2:0] seg;
        logic       last;
    } ctrl_t;

    // sequencer to datapath
    typedef struct packed {
        ctrl_t ctrl;
        logic  go;
        logic  final_line;
    } dp_cmd_t;

    localparam int PROG_LEN = 22;
    localparam int PC_W = $clog2(PROG_LEN);

    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] p;
        case (digit)
            4'h0: p = 7'h3F;
            4'h1: p = 7'h06;
            4'h2: p = 7'h5B;
            4'h3: p = 7'h4F;
            4'h4: p = 7'h66;
            4'h5: p = 7'h6D;
            4'h6: p = 7'h7D;
            4'h7: p = 7'h07;
            4'h8: p = 7'h7F;
            4'h9: p = 7'h6F;
            4'hA: p = 7'h77;
            4'hB: p = 7'h7C;
            4'hC: p = 7'h39;
            4'hD: p = 7'h5E;
            4'hE: p = 7'h79;
            default: p = 7'h71;
        endcase
        return p;
    endfunction

    function automatic ctrl_t mk(input logic [1:0] op, input logic horiz,
                                 input logic [1:0] xs, input logic [2:0] ys,
                                 input logic ye, input logic [2:0] seg,
                                 input logic last);
        ctrl_t c;
        c.op     = op;
        c.horiz  = horiz;
        c.xs_sel = xs;
        c.ys_sel = ys;
        c.ye_sel = ye;
        c.seg    = seg;
        c.last   = last;
        return c;
    endfunction

    // control program: per segment a load step and two looping emit steps
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        case (pc)
            5'd0:  c = mk(OP_CALC,  1'b0, XS_L, YS_TOP, YE_T2, 3'd0, 1'b0);
            // segment a
            5'd1:  c = mk(OP_LOAD,  1'b1, XS_A, YS_TOP, YE_T2, 3'd0, 1'b0);
            5'd2:  c = mk(OP_EMIT1, 1'b1, XS_A, YS_TOP, YE_T2, 3'd0, 1'b0);
            5'd3:  c = mk(OP_EMIT2, 1'b1, XS_A, YS_TOP, YE_T2, 3'd0, 1'b0);
            // segment b
            5'd4:  c = mk(OP_LOAD,  1'b0, XS_R, YS_T1,  YE_T2, 3'd1, 1'b0);
            5'd5:  c = mk(OP_EMIT1, 1'b0, XS_R, YS_T1,  YE_T2, 3'd1, 1'b0);
            5'd6:  c = mk(OP_EMIT2, 1'b0, XS_R, YS_T1,  YE_T2, 3'd1, 1'b0);
            // segment c
            5'd7:  c = mk(OP_LOAD,  1'b0, XS_R, YS_B1,  YE_B2, 3'd2, 1'b0);
            5'd8:  c = mk(OP_EMIT1, 1'b0, XS_R, YS_B1,  YE_B2, 3'd2, 1'b0);
            5'd9:  c = mk(OP_EMIT2, 1'b0, XS_R, YS_B1,  YE_B2, 3'd2, 1'b0);
            // segment d
            5'd10: c = mk(OP_LOAD,  1'b1, XS_A, YS_BOT, YE_T2, 3'd3, 1'b0);
            5'd11: c = mk(OP_EMIT1, 1'b1, XS_A, YS_BOT, YE_T2, 3'd3, 1'b0);
            5'd12: c = mk(OP_EMIT2, 1'b1, XS_A, YS_BOT, YE_T2, 3'd3, 1'b0);
            // segment e
            5'd13: c = mk(OP_LOAD,  1'b0, XS_L, YS_B1,  YE_B2, 3'd4, 1'b0);
            5'd14: c = mk(OP_EMIT1, 1'b0, XS_L, YS_B1,  YE_B2, 3'd4, 1'b0);
            5'd15: c = mk(OP_EMIT2, 1'b0, XS_L, YS_B1,  YE_B2, 3'd4, 1'b0);
            // segment f
            5'd16: c = mk(OP_LOAD,  1'b0, XS_L, YS_T1,  YE_T2, 3'd5, 1'b0);
            5'd17: c = mk(OP_EMIT1, 1'b0, XS_L, YS_T1,  YE_T2, 3'd5, 1'b0);
            5'd18: c = mk(OP_EMIT2, 1'b0, XS_L, YS_T1,  YE_T2, 3'd5, 1'b0);
            // segment g
            5'd19: c = mk(OP_LOAD,  1'b1, XS_A, YS_MID, YE_T2, 3'd6, 1'b0);
            5'd20: c = mk(OP_EMIT1, 1'b1, XS_A, YS_MID, YE_T2, 3'd6, 1'b0);
            5'd21: c = mk(OP_EMIT2, 1'b1, XS_A, YS_MID, YE_T2, 3'd6, 1'b1);
            default: c = mk(OP_CALC, 1'b0, XS_L, YS_TOP, YE_T2, 3'd0, 1'b1);
        endcase
        return c;
    endfunction

endpackage

// ===== sv/ssg_sequencer.sv =====
// ----------------------------------------------------------------------------
// ssg_sequencer
// Step counter, loop counter and program table lookup; issues one control
// word per step to the datapath.
// ----------------------------------------------------------------------------
module ssg_sequencer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ssg_pkg::HALF_W-1:0] half_depth,
    input  logic                       emit_ok,
    output logic                       busy,
    output ssg_pkg::dp_cmd_t           cmd
);

    logic                         busy_reg, busy_next;
    logic [ssg_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic [ssg_pkg::HALF_W-1:0]   cnt_reg, cnt_next;
    ssg_pkg::ctrl_t               ctrl;
    logic                         is_emit;
    logic                         loop_end;
    logic                         go;

    assign ctrl     = ssg_pkg::ucode(pc_reg);
    assign is_emit  = (ctrl.op == ssg_pkg::OP_EMIT1) || (ctrl.op == ssg_pkg::OP_EMIT2);
    assign loop_end = (cnt_reg == half_depth - ssg_pkg::HALF_W'(1));
    // emit steps wait for a free output slot
    assign go       = busy_reg && (!is_emit || emit_ok);

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
            cnt_next  = '0;
        end
        else if (go)
        begin
            if (is_emit)
            begin
                if (loop_end)
                begin
                    cnt_next = '0;
                    if (ctrl.last)
                        busy_next = 1'b0;
                    else
                        pc_next = pc_reg + ssg_pkg::PC_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg + ssg_pkg::HALF_W'(1);
                end
            end
            else
            begin
                pc_next = pc_reg + ssg_pkg::PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy           = busy_reg;
    assign cmd.ctrl       = ctrl;
    assign cmd.go         = go;
    assign cmd.final_line = ctrl.last && (ctrl.op == ssg_pkg::OP_EMIT2) && loop_end;

endmodule

// ===== sv/ssg_datapath.sv =====
// ----------------------------------------------------------------------------
// ssg_datapath
// Glyph base terms, current line endpoints with step adders, and the
// output register of the line channel.
// ----------------------------------------------------------------------------
module ssg_datapath #(
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [3:0]                  digit_lo,
    input  logic [ssg_pkg::POS_W-1:0]   origin_x,
    input  logic [ssg_pkg::POS_W-1:0]   origin_y,
    input  logic [ssg_pkg::COLOR_W-1:0] fore_color,
    input  logic [ssg_pkg::COLOR_W-1:0] back_color,
    input  logic [ssg_pkg::SIZE_W-1:0]  glyph_w,
    input  logic [ssg_pkg::SIZE_W-1:0]  glyph_h,
    input  logic [ssg_pkg::DEPTH_W-1:0] depth,
    input  logic [ssg_pkg::HALF_W-1:0]  half_depth,
    input  ssg_pkg::dp_cmd_t            cmd,
    output logic                        emit_ok,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ssg_pkg::OUT_W-1:0]   start_x,
    output logic [ssg_pkg::OUT_W-1:0]   start_y,
    output logic [ssg_pkg::OUT_W-1:0]   end_x,
    output logic [ssg_pkg::OUT_W-1:0]   end_y,
    output logic [ssg_pkg::COLOR_W-1:0] line_color,
    output logic                        final_line
);

    // exact coordinates stay within 14 bits signed
    localparam int CW = (COORD_BITS > 14) ? COORD_BITS : 14;

    function automatic logic [ssg_pkg::OUT_W-1:0] wrap_coord(input logic signed [CW-1:0] v);
        logic signed [COORD_BITS-1:0] t;
        logic signed [CW-1:0]         e;
        t = v[COORD_BITS-1:0];
        e = CW'(t);
        return e[ssg_pkg::OUT_W-1:0];
    endfunction

    // captured item
    logic [6:0]                  segs_reg;
    logic [ssg_pkg::POS_W-1:0]   ox_reg, oy_reg;
    logic [ssg_pkg::COLOR_W-1:0] fg_reg, bg_reg;

    // base terms
    logic signed [CW-1:0] xa_reg, xb_reg, xr_reg, xl_reg;
    logic signed [CW-1:0] y0_reg, yt1_reg, yt2_reg, yb1_reg, yb2_reg, ybot_reg, ymid_reg;

    // current line
    logic signed [CW-1:0]        sx_reg, sy_reg, ex_reg, ey_reg;
    logic [ssg_pkg::COLOR_W-1:0] color_reg;

    // output slot
    logic                        out_valid_reg, out_valid_next;
    logic [ssg_pkg::OUT_W-1:0]   osx_reg, osy_reg, oex_reg, oey_reg;
    logic [ssg_pkg::COLOR_W-1:0] ocolor_reg;
    logic                        ofinal_reg;

    logic signed [CW-1:0] xo, yo, ww, hh, dd, dh, gp, hd2;
    logic signed [CW-1:0] xs_base, ys_base, ye_base;
    logic                 do_calc, do_load, do_emit, emit1, emit2;
    logic signed [CW-1:0] one;

    assign xo  = CW'(ox_reg);
    assign yo  = CW'(oy_reg);
    assign ww  = CW'(glyph_w);
    assign hh  = CW'(glyph_h);
    assign hd2 = CW'(glyph_h >> 1);
    assign dd  = CW'(depth);
    assign dh  = CW'(half_depth);
    assign gp  = CW'(ssg_pkg::GAP);
    assign one = CW'(1);

    assign do_calc = cmd.go && (cmd.ctrl.op == ssg_pkg::OP_CALC);
    assign do_load = cmd.go && (cmd.ctrl.op == ssg_pkg::OP_LOAD);
    assign emit1   = cmd.ctrl.op == ssg_pkg::OP_EMIT1;
    assign emit2   = cmd.ctrl.op == ssg_pkg::OP_EMIT2;
    assign do_emit = cmd.go && (emit1 || emit2);

    always_comb
    begin
        case (cmd.ctrl.xs_sel)
            ssg_pkg::XS_A: xs_base = xa_reg;
            ssg_pkg::XS_R: xs_base = xr_reg;
            default:       xs_base = xl_reg;
        endcase
        case (cmd.ctrl.ys_sel)
            ssg_pkg::YS_TOP: ys_base = y0_reg;
            ssg_pkg::YS_T1:  ys_base = yt1_reg;
            ssg_pkg::YS_B1:  ys_base = yb1_reg;
            ssg_pkg::YS_BOT: ys_base = ybot_reg;
            default:         ys_base = ymid_reg;
        endcase
        ye_base = (cmd.ctrl.ye_sel == ssg_pkg::YE_B2) ? yb2_reg : yt2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            segs_reg <= ssg_pkg::seg_pattern(digit_lo);
            ox_reg   <= origin_x;
            oy_reg   <= origin_y;
            fg_reg   <= fore_color;
            bg_reg   <= back_color;
        end
        if (do_calc)
        begin
            xa_reg   <= xo + dd + gp;
            xb_reg   <= xo + ww - dd - gp;
            xr_reg   <= xo + ww - dd;
            xl_reg   <= xo;
            y0_reg   <= yo;
            yt1_reg  <= yo + dd + gp;
            yt2_reg  <= yo + hd2 - dh - gp;
            yb1_reg  <= yo + hd2 + dh + gp;
            yb2_reg  <= yo + hh - dd - gp;
            ybot_reg <= yo + hh - dd;
            ymid_reg <= yo + hd2 - dh;
        end
        if (do_load)
        begin
            sx_reg    <= xs_base;
            sy_reg    <= ys_base;
            ex_reg    <= cmd.ctrl.horiz ? xb_reg : xs_base;
            ey_reg    <= cmd.ctrl.horiz ? ys_base : ye_base;
            color_reg <= segs_reg[cmd.ctrl.seg] ? fg_reg : bg_reg;
        end
        else if (do_emit)
        begin
            // bevel: each loop widens or narrows the bar by one pixel a line
            sx_reg <= (emit1 && cmd.ctrl.horiz)  ? sx_reg - one : sx_reg + one;
            sy_reg <= (emit1 && !cmd.ctrl.horiz) ? sy_reg - one : sy_reg + one;
            ex_reg <= (emit2 && cmd.ctrl.horiz)  ? ex_reg - one : ex_reg + one;
            ey_reg <= (emit2 && !cmd.ctrl.horiz) ? ey_reg - one : ey_reg + one;
        end
        if (do_emit)
        begin
            osx_reg    <= wrap_coord(sx_reg);
            osy_reg    <= wrap_coord(sy_reg);
            oex_reg    <= wrap_coord(ex_reg);
            oey_reg    <= wrap_coord(ey_reg);
            ocolor_reg <= color_reg;
            ofinal_reg <= cmd.final_line;
        end
    end

    always_comb
    begin
        if (do_emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign emit_ok    = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign start_x    = osx_reg;
    assign start_y    = osy_reg;
    assign end_x      = oex_reg;
    assign end_y      = oey_reg;
    assign line_color = ocolor_reg;
    assign final_line = ofinal_reg;

endmodule

// ===== sv/seven_segment_glyph_line_generator.sv =====
// ----------------------------------------------------------------------------
// seven_segment_glyph_line_generator
// Turns one hex digit into the line draw commands of a beveled
// seven-segment glyph, segments a through g in order.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// -------  ---------  ---------------------  ------------------------------------
// in       input      in_valid / in_ready    digit, origin_x/y, fore/back_color
// out      output     out_valid / out_ready  start_x/y, end_x/y, line_color,
//                                            final_line
// cfg      input      cfg_we (no wait)       cfg_index, cfg_data
//
// from one accept to the next, a glyph goes through the accept, a step that
// latches the base terms, one load step per segment, then 14*(depth/2) lines
// at one line per cycle while the output takes them, counted by the loop
// counter of the sequencer. at the largest depth that is 56 lines.
// digits above fifteen and depths below two are accepted but give no lines.
// a stalled output holds the sequencer on its emit step; the last line sits
// in the output register while the next transaction is already accepted.
// reset clears the sequencer and output valid and loads the register defaults.
//
module seven_segment_glyph_line_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssg_pkg::CFG_W-1:0]     cfg_data,
    // digit transactions
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ssg_pkg::DIGIT_W-1:0]   digit,
    input  logic [ssg_pkg::POS_W-1:0]     origin_x,
    input  logic [ssg_pkg::POS_W-1:0]     origin_y,
    input  logic [ssg_pkg::COLOR_W-1:0]   fore_color,
    input  logic [ssg_pkg::COLOR_W-1:0]   back_color,
    // line transactions
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ssg_pkg::OUT_W-1:0]     start_x,
    output logic [ssg_pkg::OUT_W-1:0]     start_y,
    output logic [ssg_pkg::OUT_W-1:0]     end_x,
    output logic [ssg_pkg::OUT_W-1:0]     end_y,
    output logic [ssg_pkg::COLOR_W-1:0]   line_color,
    output logic                          final_line
);

    // configuration registers
    logic [ssg_pkg::SIZE_W-1:0]  width_reg;
    logic [ssg_pkg::SIZE_W-1:0]  height_reg;
    logic [ssg_pkg::DEPTH_W-1:0] depth_reg;

    // effective depth and half depth
    logic [ssg_pkg::DEPTH_W-1:0] depth_sat;
    logic [ssg_pkg::HALF_W-1:0]  half_depth;

    logic             busy;
    logic             in_fire;
    logic             skip;
    logic             emit_ok;
    ssg_pkg::dp_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ssg_pkg::RESET_WIDTH;
            height_reg <= ssg_pkg::RESET_HEIGHT;
            depth_reg  <= ssg_pkg::RESET_DEPTH;
        end
        else if (cfg_we)
        begin
            // writes to an index past the list fall through the case
            case (cfg_index)
                ssg_pkg::CFG_GLYPH_WIDTH:  width_reg  <= cfg_data;
                ssg_pkg::CFG_GLYPH_HEIGHT: height_reg <= cfg_data;
                ssg_pkg::CFG_BAR_DEPTH:    depth_reg  <= cfg_data[ssg_pkg::DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // depth saturates at the largest bar thickness
    assign depth_sat  = (depth_reg > ssg_pkg::DEPTH_W'(ssg_pkg::MAX_DEPTH)) ?
                        ssg_pkg::DEPTH_W'(ssg_pkg::MAX_DEPTH) : depth_reg;
    assign half_depth = ssg_pkg::HALF_W'(depth_sat >> 1);

    // one glyph at a time; a new transaction waits for the program to finish
    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    // no lines at all: digit out of the hex range or bars of zero lines
    assign skip = (digit > ssg_pkg::DIGIT_W'(15)) || (half_depth == '0);

    ssg_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_fire && !skip),
        .half_depth (half_depth),
        .emit_ok    (emit_ok),
        .busy       (busy),
        .cmd        (cmd)
    );

    ssg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .digit_lo   (digit[3:0]),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .fore_color (fore_color),
        .back_color (back_color),
        .glyph_w    (width_reg),
        .glyph_h    (height_reg),
        .depth      (depth_sat),
        .half_depth (half_depth),
        .cmd        (cmd),
        .emit_ok    (emit_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .final_line (final_line)
    );

endmodule
